// File: src/sws_pkg.sv
`timescale 1ns / 1ps

package sws_pkg;

  localparam int unsigned MAX_HALF_WINDOW = 31;
  localparam int unsigned SAMPLE_BITS     = 32;

  localparam int unsigned HW_W    = 5;
  localparam int unsigned DEV_W   = 40;
  localparam int unsigned DIVD_W  = 64;
  localparam int unsigned DIVS_W  = 40;
  localparam int unsigned SKEW_W  = 24;

  localparam logic [1:0] CFG_HALF_WINDOW = 2'd0;
  localparam logic [1:0] CFG_GAP_MARKER  = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: src/sws_div.sv
`timescale 1ns / 1ps

module sws_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [sws_pkg::DIVD_W-1:0]        dividend_i,
  input  logic [sws_pkg::DIVS_W-1:0]        divisor_i,
  output logic [sws_pkg::DIVD_W-1:0]        quotient_o,
  output sws_pkg::unit_stat_t               stat_o
);

  logic [sws_pkg::DIVD_W-1:0] dvd_q, dvd_d;
  logic [sws_pkg::DIVS_W-1:0] dvs_q, dvs_d;
  logic [sws_pkg::DIVS_W:0]   rem_q, rem_d, rem_sh;
  logic [5:0]                 cnt_q, cnt_d;
  logic                       busy_q, busy_d, done_q, done_d;

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[sws_pkg::DIVS_W-1:0], dvd_q[sws_pkg::DIVD_W-1]};
    if (start_i) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = 6'd63;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        dvd_d = {dvd_q[sws_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        dvd_d = {dvd_q[sws_pkg::DIVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign quotient_o  = dvd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: src/sws_sqrt.sv
`timescale 1ns / 1ps

module sws_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [63:0]          value_i,
  output logic [31:0]          root_o,
  output sws_pkg::unit_stat_t  stat_o
);

  logic [63:0] v_q, v_d, r_q, r_d, bit_q, bit_d, trial;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    v_d    = v_q;
    r_d    = r_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = r_q + bit_q;
    if (start_i) begin
      v_d    = value_i;
      r_d    = '0;
      bit_d  = 64'd1 << 62;
      cnt_d  = 5'd31;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d = v_q - trial;
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign root_o      = r_q[31:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: src/sliding_window_skewness.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload
// s_axis    in   tdata: sample[31:0]; tlast: segment_end
// m_axis    out  tdata: skewness[23:0]; tuser: gap_out, degenerate; tlast: last_out
// cfg       in   index 0 half_window, 1 gap_marker; data[31:0]
//
// One input transaction is taken in the idle state, then 0 to 32 results follow.
// Each result for a window of W samples is computed by three passes over the
// sample store, a 32-step square root and the 64-step divider used twice.
// Reset clears the state, counters, configuration, flags and the output valid.
// A result waits in the output register; the sequencer stalls only when the
// next result is ready and that register is still held.

module sliding_window_skewness (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // sample[31:0]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // skewness[23:0]
  output logic [1:0]  m_axis_tuser_o,   // gap_out[0], degenerate[1]
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned DW = sws_pkg::DEV_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHECK = 5'd1;
  localparam logic [4:0] S_CRD   = 5'd2;
  localparam logic [4:0] S_CGAP  = 5'd3;
  localparam logic [4:0] S_P1R   = 5'd4;
  localparam logic [4:0] S_P1A   = 5'd5;
  localparam logic [4:0] S_P2R   = 5'd6;
  localparam logic [4:0] S_P2A   = 5'd7;
  localparam logic [4:0] S_P2B   = 5'd8;
  localparam logic [4:0] S_LEN   = 5'd9;
  localparam logic [4:0] S_P3R   = 5'd10;
  localparam logic [4:0] S_P3A   = 5'd11;
  localparam logic [4:0] S_P3B   = 5'd12;
  localparam logic [4:0] S_P3C   = 5'd13;
  localparam logic [4:0] S_P3D   = 5'd14;
  localparam logic [4:0] S_NB    = 5'd15;
  localparam logic [4:0] S_SQ    = 5'd16;
  localparam logic [4:0] S_SQW   = 5'd17;
  localparam logic [4:0] S_DIV1  = 5'd18;
  localparam logic [4:0] S_DIV1W = 5'd19;
  localparam logic [4:0] S_MUL   = 5'd20;
  localparam logic [4:0] S_DIV2  = 5'd21;
  localparam logic [4:0] S_DIV2W = 5'd22;
  localparam logic [4:0] S_SAT   = 5'd23;
  localparam logic [4:0] S_OUT   = 5'd24;

  logic [4:0] state_q, state_d;

  logic [sws_pkg::HW_W-1:0] hw_q, hw_d, h;
  logic signed [31:0]       gap_q, gap_d;
  logic [6:0]               rcv_q, rcv_d, emt_q, emt_d, pending, pend_m1;
  logic                     seg_long_q, seg_long_d, last_q, last_d, rlast_q, rlast_d;
  logic [5:0]               cnt_q, cnt_d, base_q, base_d, span_q, span_d, k_q, k_d;
  logic [5:0]               n_q, n_d, len_q, len_d;
  logic [4:0]               left, right;
  logic signed [DW-1:0]     sum_q, sum_d, prod_q, prod_d, x_ext, n_ext, dev;
  logic [DW-1:0]            maxmag_q, maxmag_d, mag;
  logic [15:0]              mag16_q, mag16_d;
  logic                     negel_q, negel_d;
  logic [31:0]              sq_q, sq_d, s_q, s_d, u_q, u_d;
  logic [47:0]              cube;
  logic [DW-1:0]            b2_q, b2_d;
  logic signed [55:0]       a3_q, a3_d;
  logic [55:0]              a_abs;
  logic [45:0]              nb_q, nb_d;
  logic [63:0]              us_q, us_d, qc;
  logic [23:0]              res_skew_q, res_skew_d;
  logic                     res_gap_q, res_gap_d, res_deg_q, res_deg_d;
  logic                     out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [23:0]              out_skew_q, out_skew_d;
  logic                     out_gap_q, out_gap_d, out_deg_q, out_deg_d;
  logic                     stop, el_last, rd_gap;

  logic [31:0] mem [64];
  logic [31:0] rd_data_q;
  logic [5:0]  rd_addr;
  logic        wr_en;

  logic [63:0]         div_dvd, div_quot;
  logic [39:0]         div_dvs;
  logic                div_start, sqrt_start;
  logic [31:0]         sqrt_root;
  sws_pkg::unit_stat_t div_stat, sqrt_stat;

  sws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_quot),
    .stat_o     (div_stat)
  );

  sws_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i ({nb_q, 18'b0}),
    .root_o  (sqrt_root),
    .stat_o  (sqrt_stat)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign wr_en           = s_axis_tvalid_i && s_axis_tready_o;

  assign h       = (hw_q < sws_pkg::HW_W'(sws_pkg::MAX_HALF_WINDOW)) ? hw_q
                   : sws_pkg::HW_W'(sws_pkg::MAX_HALF_WINDOW);
  assign pending = rcv_q - emt_q;
  assign pend_m1 = pending - 7'd1;
  assign stop    = (pending == 7'd0) || (cnt_q == 6'd32) ||
                   (!last_q && (pending <= {2'b0, h}));
  assign left    = seg_long_q ? h : ((emt_q < {2'b0, h}) ? emt_q[4:0] : h);
  assign right   = (pend_m1 > {2'b0, h}) ? h : pend_m1[4:0];
  assign el_last = (k_q == span_q);
  assign rd_gap  = (rd_data_q == gap_q);

  assign x_ext = {{(DW-32){rd_data_q[31]}}, rd_data_q};
  assign n_ext = {{(DW-6){1'b0}}, n_q};
  assign dev   = prod_q - sum_q;
  assign mag   = dev[DW-1] ? DW'(-dev) : DW'(dev);
  assign cube  = 48'(sq_q) * 48'(mag16_q);
  assign a_abs = a3_q[55] ? 56'(-a3_q) : 56'(a3_q);

  always_comb begin
    if (state_q == S_CRD) rd_addr = emt_q[5:0];
    else                  rd_addr = base_q + k_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[rcv_q[5:0]] <= s_axis_tdata_i;
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    div_start  = (state_q == S_DIV1) || (state_q == S_DIV2);
    sqrt_start = (state_q == S_SQ);
    if (state_q == S_DIV2) begin
      div_dvd = us_q;
      div_dvs = {b2_q[DW-2:0], 1'b0};
    end else begin
      div_dvd = 64'(a_abs) << 8;
      div_dvs = b2_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    hw_d       = hw_q;
    gap_d      = gap_q;
    rcv_d      = rcv_q;
    emt_d      = emt_q;
    seg_long_d = seg_long_q;
    last_d     = last_q;
    rlast_d    = rlast_q;
    cnt_d      = cnt_q;
    base_d     = base_q;
    span_d     = span_q;
    k_d        = k_q;
    n_d        = n_q;
    len_d      = len_q;
    sum_d      = sum_q;
    prod_d     = prod_q;
    maxmag_d   = maxmag_q;
    mag16_d    = mag16_q;
    negel_d    = negel_q;
    sq_d       = sq_q;
    b2_d       = b2_q;
    a3_d       = a3_q;
    nb_d       = nb_q;
    s_d        = s_q;
    u_d        = u_q;
    us_d       = us_q;
    qc         = '0;
    res_skew_d = res_skew_q;
    res_gap_d  = res_gap_q;
    res_deg_d  = res_deg_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_skew_d = out_skew_q;
    out_gap_d  = out_gap_q;
    out_deg_d  = out_deg_q;
    out_last_d = out_last_q;

    if (cfg_valid_i) begin
      if (cfg_index_i == sws_pkg::CFG_HALF_WINDOW) hw_d = cfg_data_i[sws_pkg::HW_W-1:0];
      else if (cfg_index_i == sws_pkg::CFG_GAP_MARKER) gap_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (wr_en) begin
          rcv_d  = rcv_q + 7'd1;
          if (rcv_q + 7'd1 == 7'd64) seg_long_d = 1'b1;
          last_d = s_axis_tlast_i;
          cnt_d  = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stop) begin
          if (last_q) begin
            rcv_d      = '0;
            emt_d      = '0;
            seg_long_d = 1'b0;
          end
          state_d = S_IDLE;
        end else begin
          base_d  = emt_q[5:0] - {1'b0, left};
          span_d  = {1'b0, left} + {1'b0, right};
          rlast_d = last_q && (pending == 7'd1);
          state_d = S_CRD;
        end
      end
      S_CRD: state_d = S_CGAP;
      S_CGAP: begin
        res_skew_d = '0;
        res_deg_d  = 1'b0;
        res_gap_d  = rd_gap;
        sum_d      = '0;
        n_d        = '0;
        k_d        = '0;
        state_d    = rd_gap ? S_OUT : S_P1R;
      end
      S_P1R: state_d = S_P1A;
      S_P1A: begin
        if (!rd_gap) begin
          sum_d = sum_q + x_ext;
          n_d   = n_q + 6'd1;
        end
        if (el_last) begin
          k_d      = '0;
          maxmag_d = '0;
          state_d  = S_P2R;
        end else begin
          k_d     = k_q + 6'd1;
          state_d = S_P1R;
        end
      end
      S_P2R: state_d = S_P2A;
      S_P2A: begin
        prod_d = x_ext * n_ext;
        if (!rd_gap) begin
          state_d = S_P2B;
        end else if (el_last) begin
          k_d     = '0;
          len_d   = '0;
          state_d = S_LEN;
        end else begin
          k_d     = k_q + 6'd1;
          state_d = S_P2R;
        end
      end
      S_P2B: begin
        if (mag > maxmag_q) maxmag_d = mag;
        if (el_last) begin
          k_d     = '0;
          len_d   = '0;
          state_d = S_LEN;
        end else begin
          k_d     = k_q + 6'd1;
          state_d = S_P2R;
        end
      end
      S_LEN: begin
        if (len_q == 6'd0 && maxmag_q == '0) begin
          res_deg_d = 1'b1;
          state_d   = S_OUT;
        end else if (maxmag_q != '0) begin
          maxmag_d = maxmag_q >> 1;
          len_d    = len_q + 6'd1;
        end else begin
          b2_d    = '0;
          a3_d    = '0;
          state_d = S_P3R;
        end
      end
      S_P3R: state_d = S_P3A;
      S_P3A: begin
        prod_d = x_ext * n_ext;
        if (!rd_gap) begin
          state_d = S_P3B;
        end else if (el_last) begin
          state_d = S_NB;
        end else begin
          k_d     = k_q + 6'd1;
          state_d = S_P3R;
        end
      end
      S_P3B: begin
        negel_d = dev[DW-1];
        if (len_q > 6'd16) mag16_d = 16'(mag >> (len_q - 6'd16));
        else               mag16_d = 16'(mag << (6'd16 - len_q));
        state_d = S_P3C;
      end
      S_P3C: begin
        sq_d    = 32'(mag16_q) * 32'(mag16_q);
        state_d = S_P3D;
      end
      S_P3D: begin
        b2_d = b2_q + DW'(sq_q);
        if (negel_q) a3_d = a3_q - $signed({8'b0, cube});
        else         a3_d = a3_q + $signed({8'b0, cube});
        if (el_last) begin
          state_d = S_NB;
        end else begin
          k_d     = k_q + 6'd1;
          state_d = S_P3R;
        end
      end
      S_NB: begin
        nb_d    = 46'(n_q) * 46'(b2_q);
        state_d = S_SQ;
      end
      S_SQ: state_d = S_SQW;
      S_SQW: begin
        if (sqrt_stat.done) begin
          s_d     = sqrt_root;
          state_d = S_DIV1;
        end
      end
      S_DIV1: state_d = S_DIV1W;
      S_DIV1W: begin
        if (div_stat.done) begin
          u_d     = div_quot[31:0];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        us_d    = 64'(u_q) * 64'(s_q);
        state_d = S_DIV2;
      end
      S_DIV2: state_d = S_DIV2W;
      S_DIV2W: begin
        if (div_stat.done) state_d = S_SAT;
      end
      S_SAT: begin
        if (a3_q[55]) begin
          qc = (div_quot > 64'd8388608) ? 64'd8388608 : div_quot;
          res_skew_d = 24'(64'd0 - qc);
        end else begin
          qc = (div_quot > 64'd8388607) ? 64'd8388607 : div_quot;
          res_skew_d = qc[23:0];
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_skew_d  = res_skew_q;
          out_gap_d   = res_gap_q;
          out_deg_d   = res_deg_q;
          out_last_d  = rlast_q;
          emt_d       = emt_q + 7'd1;
          cnt_d       = cnt_q + 6'd1;
          state_d     = S_CHECK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hw_q        <= '0;
      gap_q       <= '0;
      rcv_q       <= '0;
      emt_q       <= '0;
      seg_long_q  <= 1'b0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      gap_q       <= gap_d;
      rcv_q       <= rcv_d;
      emt_q       <= emt_d;
      seg_long_q  <= seg_long_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rlast_q    <= rlast_d;
    base_q     <= base_d;
    span_q     <= span_d;
    k_q        <= k_d;
    n_q        <= n_d;
    len_q      <= len_d;
    sum_q      <= sum_d;
    prod_q     <= prod_d;
    maxmag_q   <= maxmag_d;
    mag16_q    <= mag16_d;
    negel_q    <= negel_d;
    sq_q       <= sq_d;
    b2_q       <= b2_d;
    a3_q       <= a3_d;
    nb_q       <= nb_d;
    s_q        <= s_d;
    u_q        <= u_d;
    us_q       <= us_d;
    res_skew_q <= res_skew_d;
    res_gap_q  <= res_gap_d;
    res_deg_q  <= res_deg_d;
    out_skew_q <= out_skew_d;
    out_gap_q  <= out_gap_d;
    out_deg_q  <= out_deg_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_skew_q;
  assign m_axis_tuser_o  = {out_deg_q, out_gap_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 6'd32) else $error("more than 32 results for one transaction");

  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending <= 7'd64) else $error("pending results overrun sample store");

  a_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_stat.busy && sqrt_stat.busy)) else $error("divider and root overlap");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[0] || m_axis_tuser_o[1]) |->
      (m_axis_tdata_o == '0) && !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("flagged result with nonzero skewness");
`endif

endmodule
